// ----- rtl/itf_pkg.sv -----
// Package for the integer-to-text formatter: word types, conversion codes,
// flag positions, ASCII constants and the digit-to-character function.
// No dependencies.
package itf_pkg;

   typedef struct packed {
      logic [63:0]       value_bits;
      logic [1:0]        operand_size;
      logic [2:0]        conversion;
      logic [4:0]        format_flags;
      logic [6:0]        field_width;
      logic signed [7:0] digit_precision;
   } req_type;

   typedef struct packed {
      logic [63:0] text_chars;
      logic [3:0]  char_count;
      logic        last_beat;
   } rsp_type;

   // Conversion codes
   localparam logic [2:0] CONV_SDEC  = 3'd0;
   localparam logic [2:0] CONV_UDEC  = 3'd1;
   localparam logic [2:0] CONV_HEXL  = 3'd2;
   localparam logic [2:0] CONV_HEXU  = 3'd3;
   localparam logic [2:0] CONV_OCT   = 3'd4;
   localparam logic [2:0] CONV_BIN   = 3'd5;
   localparam logic [2:0] CONV_PTR   = 3'd6;
   // Reserved code, formatted as unsigned decimal
   localparam logic [2:0] CONV_RSVD  = 3'd7;

   // Flag bit positions
   localparam int FMTBIT_LEFT  = 0;
   localparam int FMTBIT_PLUS  = 1;
   localparam int FMTBIT_SPACE = 2;
   localparam int FMTBIT_ZPAD  = 3;
   localparam int FMTBIT_ALT   = 4;

   // ASCII characters
   localparam logic [7:0] CH_NONE  = 8'h00;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_UX    = 8'h58;
   localparam logic [7:0] CH_LB    = 8'h62;
   localparam logic [7:0] CH_LX    = 8'h78;

   // Map one digit value to its character, lower or upper case
   function automatic logic [7:0] digit_char(logic [3:0] d, logic upper);
      logic [7:0] r;
      if (d < 4'd10) begin
         r = CH_ZERO + {4'h0, d};
      end else if (upper) begin
         r = 8'h37 + {4'h0, d};
      end else begin
         r = 8'h57 + {4'h0, d};
      end
      return r;
   endfunction

endpackage

// ----- rtl/integer_to_text_formatter_top.sv -----
// Integer-to-text formatter: top level and its sequencer.
// Depends on itf_pkg (word types, codes, digit_char).
//
// Usage: the req channel takes one word per number: the operand, its size,
// the conversion, flags, field width and precision. The rsp channel returns
// the formatted text as beats of up to CHARS_PER_BEAT characters, first
// character in the lowest byte, unused bytes zero, last_beat on the final
// beat. An empty text gives one beat with char_count 0 and last_beat set.
// Both channels use valid/ready; req_ready is high only when idle.
// Per number: a setup step, then for decimal one double-dabble step per
// operand bit (8, 16, 32 or 64), then one digit per cycle from the shared
// digit extractor, a layout step, then one character per cycle (at most
// MAX_FIELD + 2) into the beat register, pausing while a full beat waits to
// be handed over.
// A stalled receiver holds the current beat in the output register and
// halts character generation until it is taken. Synchronous reset returns
// the block to idle with no beat pending.
module integer_to_text_formatter_top #(
   parameter int VALUE_BITS     = 64,
   parameter int MAX_FIELD      = 64,
   parameter int CHARS_PER_BEAT = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  itf_pkg::req_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output itf_pkg::rsp_type rsp_payload
);

   localparam int DIG_MAX = (VALUE_BITS > 16) ? VALUE_BITS : 16;
   localparam int BCD_N   = VALUE_BITS / 3 + 1;
   localparam int BCD_W   = 4 * BCD_N;
   localparam int WW      = (BCD_W > 64) ? BCD_W : 64;
   localparam int CNT_RAW = $clog2(MAX_FIELD + DIG_MAX + 4);
   localparam int CNT_W   = (CNT_RAW > 8) ? CNT_RAW : 8;
   localparam int ND_W    = $clog2(DIG_MAX + 1);
   localparam int BIT_W   = $clog2(VALUE_BITS + 1);
   localparam int DGB_W   = 4 * DIG_MAX;

   typedef enum logic [2:0] {
      ST_IDLE, ST_PREP, ST_CONV, ST_DIG, ST_LAYOUT, ST_EMIT
   } state_type;

   state_type              state_ff, state_in;
   itf_pkg::req_type       req_ff, req_in;
   logic [VALUE_BITS-1:0]  src_ff, src_in;
   logic [WW-1:0]          w_ff, w_in;
   logic [BIT_W-1:0]       step_ff, step_in;
   logic [DGB_W-1:0]       dg_ff, dg_in;
   logic [ND_W-1:0]        ndx_ff, ndx_in;
   logic                   neg_ff, neg_in;
   logic                   iszero_ff, iszero_in;
   logic [CNT_W-1:0]       lpad_ff, lpad_in;
   logic [CNT_W-1:0]       rpad_ff, rpad_in;
   logic [CNT_W-1:0]       zeros_ff, zeros_in;
   logic [CNT_W-1:0]       nd_ff, nd_in;
   logic [CNT_W-1:0]       len_ff, len_in;
   logic [7:0]             sign_ff, sign_in;
   logic [1:0]             plen_ff, plen_in;
   logic [15:0]            pre_ff, pre_in;
   logic [63:0]            beat_ff, beat_in;
   logic [3:0]             cnt_ff, cnt_in;
   logic                   last_ff, last_in;
   logic                   valid_ff, valid_in;

   // Operand preparation
   logic [7:0]            raw_bits;
   logic [BIT_W-1:0]      bits_c;
   logic [VALUE_BITS-1:0] v_c, mask_c, msb_c, x_c, mag_c;
   logic                  neg_c;
   logic                  is_dec;

   always_comb begin
      raw_bits = 8'd8 << req_ff.operand_size;
      bits_c   = (raw_bits > VALUE_BITS) ? BIT_W'(VALUE_BITS) : BIT_W'(raw_bits);
      v_c      = req_ff.value_bits[VALUE_BITS-1:0];
      mask_c   = {VALUE_BITS{1'b1}} >> (BIT_W'(VALUE_BITS) - bits_c);
      msb_c    = mask_c ^ (mask_c >> 1);
      x_c      = v_c & mask_c;
      neg_c    = (req_ff.conversion == itf_pkg::CONV_SDEC) && (|(x_c & msb_c));
      mag_c    = neg_c ? ((~x_c + 1'b1) & mask_c) : x_c;
      is_dec   = (req_ff.conversion == itf_pkg::CONV_SDEC) ||
                 (req_ff.conversion == itf_pkg::CONV_UDEC) ||
                 (req_ff.conversion == itf_pkg::CONV_RSVD);
   end

   // Double-dabble correction: add three to every BCD digit of five or more
   logic [BCD_W-1:0] adj_c;
   always_comb begin
      for (int i = 0; i < BCD_N; i++) begin
         adj_c[4*i +: 4] = (w_ff[4*i +: 4] >= 4'd5) ? (w_ff[4*i +: 4] + 4'd3)
                                                     : w_ff[4*i +: 4];
      end
   end

   // Digit extractor: take the low digit and shift the work value down
   logic [3:0]    dig_c;
   logic [WW-1:0] wsh_c;
   always_comb begin
      case (req_ff.conversion)
         itf_pkg::CONV_BIN: begin
            dig_c = {3'b000, w_ff[0]};
            wsh_c = w_ff >> 1;
         end
         itf_pkg::CONV_OCT: begin
            dig_c = {1'b0, w_ff[2:0]};
            wsh_c = w_ff >> 3;
         end
         default: begin
            dig_c = w_ff[3:0];
            wsh_c = w_ff >> 4;
         end
      endcase
   end

   // Layout of the text segments
   logic             left_c, has_prec, zfill_c, is_ptr;
   logic [CNT_W-1:0] fw_c, width_c, pr_c, prec_c, ndr_c, nde_c, zer_c, body_c, pad_c;
   logic [7:0]       sgn_c;
   logic [1:0]       pl_c;
   logic [15:0]      pr16_c;
   always_comb begin
      is_ptr   = (req_ff.conversion == itf_pkg::CONV_PTR);
      left_c   = req_ff.format_flags[itf_pkg::FMTBIT_LEFT];
      has_prec = !req_ff.digit_precision[7];
      fw_c     = CNT_W'(req_ff.field_width);
      width_c  = (fw_c > CNT_W'(MAX_FIELD)) ? CNT_W'(MAX_FIELD) : fw_c;
      pr_c     = CNT_W'(req_ff.digit_precision[6:0]);
      prec_c   = (pr_c > CNT_W'(MAX_FIELD)) ? CNT_W'(MAX_FIELD) : pr_c;
      ndr_c    = CNT_W'(ndx_ff);
      nde_c    = (has_prec && prec_c == '0 && iszero_ff) ? '0 : ndr_c;
      zer_c    = (has_prec && prec_c > nde_c) ? prec_c - nde_c : '0;
      sgn_c    = itf_pkg::CH_NONE;
      if (req_ff.conversion == itf_pkg::CONV_SDEC) begin
         if (neg_ff) begin
            sgn_c = itf_pkg::CH_MINUS;
         end else if (req_ff.format_flags[itf_pkg::FMTBIT_PLUS]) begin
            sgn_c = itf_pkg::CH_PLUS;
         end else if (req_ff.format_flags[itf_pkg::FMTBIT_SPACE]) begin
            sgn_c = itf_pkg::CH_SPACE;
         end
      end
      pl_c   = 2'd0;
      pr16_c = 16'h0000;
      if (req_ff.format_flags[itf_pkg::FMTBIT_ALT]) begin
         if ((req_ff.conversion == itf_pkg::CONV_HEXL ||
              req_ff.conversion == itf_pkg::CONV_HEXU) && !iszero_ff) begin
            pl_c   = 2'd2;
            pr16_c = {(req_ff.conversion == itf_pkg::CONV_HEXU) ? itf_pkg::CH_UX
                                                                 : itf_pkg::CH_LX,
                      itf_pkg::CH_ZERO};
         end else if (req_ff.conversion == itf_pkg::CONV_BIN && !iszero_ff) begin
            pl_c   = 2'd2;
            pr16_c = {itf_pkg::CH_LB, itf_pkg::CH_ZERO};
         end else if (req_ff.conversion == itf_pkg::CONV_OCT && zer_c == '0 &&
                      (!iszero_ff || nde_c == '0)) begin
            pl_c   = 2'd1;
            pr16_c = {itf_pkg::CH_NONE, itf_pkg::CH_ZERO};
         end
      end
      body_c  = nde_c + zer_c + CNT_W'(sgn_c != itf_pkg::CH_NONE) + CNT_W'(pl_c);
      pad_c   = (width_c > body_c) ? width_c - body_c : '0;
      zfill_c = req_ff.format_flags[itf_pkg::FMTBIT_ZPAD] && !left_c && !has_prec;
   end

   // Character selection for the next character of the text
   logic [7:0] ch_c;
   always_comb begin
      if (lpad_ff != '0) begin
         ch_c = itf_pkg::CH_SPACE;
      end else if (sign_ff != itf_pkg::CH_NONE) begin
         ch_c = sign_ff;
      end else if (plen_ff != 2'd0) begin
         ch_c = pre_ff[7:0];
      end else if (zeros_ff != '0) begin
         ch_c = itf_pkg::CH_ZERO;
      end else if (nd_ff != '0) begin
         ch_c = itf_pkg::digit_char(dg_ff[DGB_W-1 -: 4],
                                    req_ff.conversion == itf_pkg::CONV_HEXU);
      end else begin
         ch_c = itf_pkg::CH_SPACE;
      end
   end

   // Sequencer next state
   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      src_in    = src_ff;
      w_in      = w_ff;
      step_in   = step_ff;
      dg_in     = dg_ff;
      ndx_in    = ndx_ff;
      neg_in    = neg_ff;
      iszero_in = iszero_ff;
      lpad_in   = lpad_ff;
      rpad_in   = rpad_ff;
      zeros_in  = zeros_ff;
      nd_in     = nd_ff;
      len_in    = len_ff;
      sign_in   = sign_ff;
      plen_in   = plen_ff;
      pre_in    = pre_ff;
      beat_in   = beat_ff;
      cnt_in    = cnt_ff;
      last_in   = last_ff;
      valid_in  = valid_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            neg_in    = neg_c;
            iszero_in = (mag_c == '0);
            ndx_in    = '0;
            if (is_ptr) begin
               w_in     = WW'(v_c);
               state_in = ST_DIG;
            end else if (is_dec) begin
               w_in     = '0;
               src_in   = mag_c << (BIT_W'(VALUE_BITS) - bits_c);
               step_in  = bits_c;
               state_in = ST_CONV;
            end else begin
               w_in     = WW'(mag_c);
               state_in = ST_DIG;
            end
         end
         ST_CONV: begin
            // Shift one operand bit into the corrected BCD digits
            w_in    = WW'({adj_c[BCD_W-2:0], src_ff[VALUE_BITS-1]});
            src_in  = src_ff << 1;
            step_in = step_ff - 1'b1;
            if (step_ff == BIT_W'(1)) begin
               state_in = ST_DIG;
            end
         end
         ST_DIG: begin
            // Push the digit in at the top; the most significant ends on top
            dg_in  = {dig_c, dg_ff[DGB_W-1:4]};
            w_in   = wsh_c;
            ndx_in = ndx_ff + 1'b1;
            if (is_ptr ? (ndx_ff == ND_W'(15))
                       : (wsh_c == '0 || ndx_ff == ND_W'(DIG_MAX - 1))) begin
               state_in = ST_LAYOUT;
            end
         end
         ST_LAYOUT: begin
            beat_in  = '0;
            cnt_in   = 4'd0;
            valid_in = 1'b0;
            if (is_ptr) begin
               lpad_in  = '0;
               rpad_in  = '0;
               zeros_in = '0;
               sign_in  = itf_pkg::CH_NONE;
               plen_in  = 2'd2;
               pre_in   = {itf_pkg::CH_LX, itf_pkg::CH_ZERO};
               nd_in    = CNT_W'(16);
               len_in   = CNT_W'(18);
            end else begin
               lpad_in  = (left_c || zfill_c) ? '0 : pad_c;
               rpad_in  = left_c ? pad_c : '0;
               zeros_in = zfill_c ? zer_c + pad_c : zer_c;
               sign_in  = sgn_c;
               plen_in  = pl_c;
               pre_in   = pr16_c;
               nd_in    = nde_c;
               len_in   = body_c + pad_c;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (valid_ff) begin
               // Hold the beat until the receiver takes it
               if (rsp_ready) begin
                  valid_in = 1'b0;
                  beat_in  = '0;
                  cnt_in   = 4'd0;
                  if (last_ff) begin
                     state_in = ST_IDLE;
                  end
               end
            end else if (len_ff == '0) begin
               // Empty text: one beat with no characters
               valid_in = 1'b1;
               last_in  = 1'b1;
            end else begin
               for (int i = 0; i < CHARS_PER_BEAT; i++) begin
                  if (cnt_ff == 4'(i)) begin
                     beat_in[8*i +: 8] = ch_c;
                  end
               end
               cnt_in = cnt_ff + 4'd1;
               len_in = len_ff - 1'b1;
               if (lpad_ff != '0) begin
                  lpad_in = lpad_ff - 1'b1;
               end else if (sign_ff != itf_pkg::CH_NONE) begin
                  sign_in = itf_pkg::CH_NONE;
               end else if (plen_ff != 2'd0) begin
                  plen_in = plen_ff - 2'd1;
                  pre_in  = pre_ff >> 8;
               end else if (zeros_ff != '0) begin
                  zeros_in = zeros_ff - 1'b1;
               end else if (nd_ff != '0) begin
                  nd_in = nd_ff - 1'b1;
                  dg_in = dg_ff << 4;
               end else begin
                  rpad_in = rpad_ff - 1'b1;
               end
               if (len_ff == CNT_W'(1) || (cnt_ff + 4'd1) == 4'(CHARS_PER_BEAT)) begin
                  valid_in = 1'b1;
                  last_in  = (len_ff == CNT_W'(1));
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      req_ff    <= req_in;
      src_ff    <= src_in;
      w_ff      <= w_in;
      step_ff   <= step_in;
      dg_ff     <= dg_in;
      ndx_ff    <= ndx_in;
      neg_ff    <= neg_in;
      iszero_ff <= iszero_in;
      lpad_ff   <= lpad_in;
      rpad_ff   <= rpad_in;
      zeros_ff  <= zeros_in;
      nd_ff     <= nd_in;
      len_ff    <= len_in;
      sign_ff   <= sign_in;
      plen_ff   <= plen_in;
      pre_ff    <= pre_in;
      beat_ff   <= beat_in;
      cnt_ff    <= cnt_in;
      last_ff   <= last_in;
   end

   assign req_ready              = (state_ff == ST_IDLE);
   assign rsp_valid              = valid_ff;
   assign rsp_payload.text_chars = beat_ff;
   assign rsp_payload.char_count = cnt_ff;
   assign rsp_payload.last_beat  = last_ff;

endmodule

// ----- tb/sv/tb_integer_to_text_formatter_top.sv -----
// Testbench for the integer-to-text formatter: drives number words with random gaps,
// predicts the formatted text beats and checks every returned word against them.
// Depends on itf_pkg and integer_to_text_formatter_top.
module tb_integer_to_text_formatter_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_NUMBERS = 87;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   itf_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   itf_pkg::rsp_type rsp_payload;

   itf_pkg::req_type pending_numbers[$];
   itf_pkg::rsp_type expected_beats[$];
   int      error_count = 0;
   int      numbers_sent = 0;
   int      beats_seen = 0;
   int      idle_cycles = 0;
   int      reset_cycles = 0;
   int      req_gap = 0;
   int      rsp_gap = 0;
   bit      stimulus_done = 1'b0;
   bit      req_ready_seen = 1'b0;
   bit      rsp_seen = 1'b0;

   integer_to_text_formatter_top i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload)
   );

   always #5 clock = ~clock;

   function automatic logic [7:0] hex_char(logic [3:0] d, logic up);
      if (d < 4'd10) return itf_pkg::CH_ZERO + 8'(d);
      return (up ? 8'h37 : 8'h57) + 8'(d);
   endfunction

   // Build the text of one number and split it into expected beats
   task automatic format_number(input itf_pkg::req_type w);
      logic [7:0]  txt[$];
      logic [7:0]  dg[$];
      logic [63:0] x, msk;
      logic [7:0]  sign;
      logic [7:0]  pre[$];
      int          bits, base, width, prec, zeros, body, pad, nd, k;
      bit          has_prec, neg, iszero, upper, left;
      itf_pkg::rsp_type beat;
      width = w.field_width > 64 ? 64 : w.field_width;
      has_prec = w.digit_precision >= 0;
      prec = has_prec ? (w.digit_precision > 64 ? 64 : w.digit_precision) : 0;
      left = w.format_flags[itf_pkg::FMTBIT_LEFT];
      upper = w.conversion == itf_pkg::CONV_HEXU;
      sign = itf_pkg::CH_NONE;
      if (w.conversion == itf_pkg::CONV_PTR) begin
         txt.push_back(itf_pkg::CH_ZERO);
         txt.push_back(itf_pkg::CH_LX);
         for (int i = 15; i >= 0; i--) txt.push_back(hex_char(w.value_bits[4*i +: 4], 1'b0));
      end else begin
         bits = 8 << w.operand_size;
         msk = {64{1'b1}} >> (64 - bits);
         x = w.value_bits & msk;
         neg = 1'b0;
         if (w.conversion == itf_pkg::CONV_SDEC && x[bits-1]) begin
            neg = 1'b1;
            x = (~x + 64'd1) & msk;
         end
         iszero = x == 0;
         case (w.conversion)
            itf_pkg::CONV_HEXL, itf_pkg::CONV_HEXU: base = 16;
            itf_pkg::CONV_OCT: base = 8;
            itf_pkg::CONV_BIN: base = 2;
            default: base = 10;
         endcase
         // collect digits most significant first
         do begin
            dg.push_front(hex_char(4'(x % base), upper));
            x = x / base;
         end while (x != 0);
         if (has_prec && prec == 0 && iszero) dg.delete();
         nd = dg.size();
         zeros = (has_prec && prec > nd) ? prec - nd : 0;
         if (w.conversion == itf_pkg::CONV_SDEC) begin
            if (neg) sign = itf_pkg::CH_MINUS;
            else if (w.format_flags[itf_pkg::FMTBIT_PLUS]) sign = itf_pkg::CH_PLUS;
            else if (w.format_flags[itf_pkg::FMTBIT_SPACE]) sign = itf_pkg::CH_SPACE;
         end
         if (w.format_flags[itf_pkg::FMTBIT_ALT]) begin
            if ((w.conversion == itf_pkg::CONV_HEXL || w.conversion == itf_pkg::CONV_HEXU)
                && !iszero) begin
               pre.push_back(itf_pkg::CH_ZERO);
               pre.push_back(upper ? itf_pkg::CH_UX : itf_pkg::CH_LX);
            end else if (w.conversion == itf_pkg::CONV_BIN && !iszero) begin
               pre.push_back(itf_pkg::CH_ZERO);
               pre.push_back(itf_pkg::CH_LB);
            end else if (w.conversion == itf_pkg::CONV_OCT && zeros == 0 &&
                         (!iszero || nd == 0)) begin
               pre.push_back(itf_pkg::CH_ZERO);
            end
         end
         body = nd + zeros + (sign != itf_pkg::CH_NONE) + pre.size();
         pad = width > body ? width - body : 0;
         if (w.format_flags[itf_pkg::FMTBIT_ZPAD] && !left && !has_prec) begin
            zeros += pad;
            pad = 0;
         end
         if (!left) repeat (pad) txt.push_back(itf_pkg::CH_SPACE);
         if (sign != itf_pkg::CH_NONE) txt.push_back(sign);
         foreach (pre[i]) txt.push_back(pre[i]);
         repeat (zeros) txt.push_back(itf_pkg::CH_ZERO);
         foreach (dg[i]) txt.push_back(dg[i]);
         if (left) repeat (pad) txt.push_back(itf_pkg::CH_SPACE);
      end
      if (txt.size() == 0) begin
         beat = '0;
         beat.last_beat = 1'b1;
         expected_beats.push_back(beat);
      end
      k = 0;
      while (k < txt.size()) begin
         beat = '0;
         for (int c = 0; c < 8 && k < txt.size(); c++) begin
            beat.text_chars[8*c +: 8] = txt[k];
            beat.char_count++;
            k++;
         end
         beat.last_beat = k >= txt.size();
         expected_beats.push_back(beat);
      end
   endtask

   task automatic check_beat(input itf_pkg::rsp_type e, input itf_pkg::rsp_type a);
      if (e.text_chars !== a.text_chars || e.char_count !== a.char_count ||
          e.last_beat !== a.last_beat) begin
         error_count++;
         $display("%0t: beat mismatch: expected chars %h count %0d last %b,",
                  $realtime, e.text_chars, e.char_count, e.last_beat,
                  " got chars %h count %0d last %b",
                  a.text_chars, a.char_count, a.last_beat);
      end
   endtask

   function automatic itf_pkg::req_type random_number();
      itf_pkg::req_type w;
      w.value_bits = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0: w.value_bits = 64'($urandom_range(0, 20));
         1: w.value_bits = ~w.value_bits >> $urandom_range(0, 63);
         default: ;
      endcase
      w.operand_size = 2'($urandom_range(0, 3));
      w.conversion = 3'($urandom_range(0, 7));
      w.format_flags = 5'($urandom_range(0, 31));
      w.field_width = ($urandom_range(0, 5) == 0) ? 7'($urandom_range(0, 127))
                                                 : 7'($urandom_range(0, 24));
      case ($urandom_range(0, 5))
         0: w.digit_precision = 8'($urandom_range(0, 255));
         1, 2: w.digit_precision = -8'sd1;
         default: w.digit_precision = 8'($urandom_range(0, 24));
      endcase
      return w;
   endfunction

   function automatic itf_pkg::req_type make_number(logic [63:0] v, logic [1:0] sz,
                                                    logic [2:0] cv, logic [4:0] fl,
                                                    logic [6:0] wd, logic [7:0] pr);
      itf_pkg::req_type w;
      w.value_bits = v; w.operand_size = sz; w.conversion = cv;
      w.format_flags = fl; w.field_width = wd; w.digit_precision = pr;
      return w;
   endfunction

   // Fill the queue: directed corners first, then random numbers
   initial begin
      pending_numbers.push_back(make_number(64'h0, 2'd3, itf_pkg::CONV_SDEC, 5'h00, 7'd0,
                                            8'hff));
      pending_numbers.push_back(make_number(64'h0, 2'd3, itf_pkg::CONV_UDEC, 5'h00, 7'd0,
                                            8'd0));
      pending_numbers.push_back(make_number(64'h0, 2'd3, itf_pkg::CONV_OCT, 5'h10, 7'd0,
                                            8'd0));
      pending_numbers.push_back(make_number(64'h0, 2'd3, itf_pkg::CONV_OCT, 5'h10, 7'd0,
                                            8'hff));
      pending_numbers.push_back(make_number(64'h8000000000000000, 2'd3, itf_pkg::CONV_SDEC,
                                            5'h00, 7'd0, 8'hff));
      pending_numbers.push_back(make_number(64'hffffffffffffffff, 2'd3, itf_pkg::CONV_UDEC,
                                            5'h00, 7'd0, 8'hff));
      pending_numbers.push_back(make_number(64'h80, 2'd0, itf_pkg::CONV_SDEC, 5'h02, 7'd6,
                                            8'hff));
      pending_numbers.push_back(make_number(64'h7f, 2'd0, itf_pkg::CONV_SDEC, 5'h06, 7'd6,
                                            8'hff));
      pending_numbers.push_back(make_number(64'h7fff, 2'd1, itf_pkg::CONV_SDEC, 5'h04, 7'd0,
                                            8'hff));
      pending_numbers.push_back(make_number(64'hdeadbeef, 2'd2, itf_pkg::CONV_HEXL, 5'h10,
                                            7'd12, 8'hff));
      pending_numbers.push_back(make_number(64'hdeadbeef, 2'd2, itf_pkg::CONV_HEXU, 5'h19,
                                            7'd12, 8'hff));
      pending_numbers.push_back(make_number(64'h0, 2'd2, itf_pkg::CONV_HEXL, 5'h10, 7'd4,
                                            8'hff));
      pending_numbers.push_back(make_number(64'h1ff, 2'd1, itf_pkg::CONV_OCT, 5'h10, 7'd0,
                                            8'd6));
      pending_numbers.push_back(make_number(64'h1ff, 2'd1, itf_pkg::CONV_OCT, 5'h10, 7'd0,
                                            8'hff));
      pending_numbers.push_back(make_number(64'hffffffffffffffff, 2'd3, itf_pkg::CONV_BIN,
                                            5'h10, 7'd0, 8'hff));
      pending_numbers.push_back(make_number(64'h5, 2'd0, itf_pkg::CONV_BIN, 5'h18, 7'd10,
                                            8'hff));
      pending_numbers.push_back(make_number(64'h0123456789abcdef, 2'd0, itf_pkg::CONV_PTR,
                                            5'h1f, 7'd127, 8'd64));
      pending_numbers.push_back(make_number(64'h0, 2'd3, itf_pkg::CONV_PTR, 5'h00, 7'd0,
                                            8'd0));
      pending_numbers.push_back(make_number(64'd42, 2'd3, itf_pkg::CONV_RSVD, 5'h1f, 7'd5,
                                            8'hff));
      pending_numbers.push_back(make_number(64'hfffffffffffffffe, 2'd3, itf_pkg::CONV_SDEC,
                                            5'h0a, 7'd64, 8'hff));
      pending_numbers.push_back(make_number(64'd123, 2'd3, itf_pkg::CONV_SDEC, 5'h03, 7'd127,
                                            8'd127));
      pending_numbers.push_back(make_number(64'd123, 2'd3, itf_pkg::CONV_UDEC, 5'h08, 7'd10,
                                            8'd5));
      pending_numbers.push_back(make_number(64'd9, 2'd2, itf_pkg::CONV_UDEC, 5'h09, 7'd7,
                                            8'hff));
      repeat (RANDOM_NUMBERS) pending_numbers.push_back(random_number());
   end

   // Reset, then feed numbers at the falling edge with random gaps
   always @(negedge clock) begin
      if (reset) begin
         reset_cycles++;
         if (reset_cycles >= 4) reset <= 1'b0;
      end else if (req_valid && req_ready_seen) begin
         numbers_sent++;
         if (pending_numbers.size() != 0 && req_gap == 0) begin
            req_payload <= pending_numbers.pop_front();
            req_gap = $urandom_range(0, 4);
         end else begin
            req_valid <= 1'b0;
         end
      end else if (!req_valid) begin
         if (pending_numbers.size() == 0) begin
            stimulus_done = 1'b1;
         end else if (req_gap > 0) begin
            req_gap--;
         end else begin
            req_payload <= pending_numbers.pop_front();
            req_valid <= 1'b1;
            req_gap = $urandom_range(0, 4);
         end
      end
      // receiver side stalls
      if (!reset) begin
         if (rsp_seen) rsp_gap = $urandom_range(0, 4);
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Sample both handshakes at the rising edge
   always @(posedge clock) begin : monitor
      bit took;
      took = 1'b0;
      if (!reset && req_valid && req_ready) begin
         took = 1'b1;
         format_number(req_payload);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         took = 1'b1;
         beats_seen++;
         if (expected_beats.size() == 0) begin
            error_count++;
            $display("%0t: unexpected beat: expected none, got %h", $realtime, rsp_payload);
         end else begin
            check_beat(expected_beats.pop_front(), rsp_payload);
         end
      end
      req_ready_seen <= !reset && req_valid && req_ready;
      rsp_seen <= !reset && rsp_valid && rsp_ready;
      idle_cycles <= took ? 0 : idle_cycles + 1;
   end

   // Finish once drained, or on a stuck handshake
   initial begin
      wait (stimulus_done && !req_valid);
      while (expected_beats.size() != 0 && idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("Covered %0d numbers over all conversions, sizes and flags, %0d beats checked.",
               numbers_sent, beats_seen);
      if (error_count == 0 && expected_beats.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("watchdog expired with %0d beats outstanding", expected_beats.size());
      $display("simulation failed");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/itf_pkg.sv
rtl/integer_to_text_formatter_top.sv
tb/sv/tb_integer_to_text_formatter_top.sv
